// ===== rtl/core/fps_pkg.sv =====
package fps_pkg;

  // Store geometry
  localparam int DEPTH   = 1024;
  localparam int ADDR_W  = $clog2(DEPTH);

  // Field widths
  localparam int POS_W   = 11;
  localparam int SIZE_W  = 11;
  localparam int DELTA_W = 32;
  localparam int SUM_W   = 64;

  // Walk index: wide enough for the position field and for idx + lowbit(idx) up to 2*DEPTH
  localparam int IDX_W   = (ADDR_W + 2 > POS_W) ? ADDR_W + 2 : POS_W;

  // Stream and register port widths
  localparam int IN_DATA_W  = ((POS_W + DELTA_W + 7) / 8) * 8;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);

  // Operation codes carried on in_tuser
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register index of size_in_use
  localparam logic [APB_ADDR_W-3:0] REG_SIZE_IN_USE = '0;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY
  } state_t;

endpackage

// ===== rtl/core/fenwick_prefix_sum_unit.sv =====
// Channel | Direction | Signals                     | Payload
// in      | slave     | in_tvalid/in_tready         | tdata: position, delta; tuser: operation
// out     | master    | out_tvalid/out_tready       | tdata: prefix_total
// cfg     | APB slave | cfg_psel/penable/pwrite ... | register 0 at byte 0: size_in_use
//
// One item at a time, one read per tree node on the single memory read port; the
// write-back of an update overlaps the next read. An update at position zero or above
// min(size_in_use, 1024) is accepted and ignored. After reset a clearing pass zeroes
// all 1024 entries before the first item, and register writes are taken during it.
// A held result stalls only the next query's load.
module fenwick_prefix_sum_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [fps_pkg::IN_DATA_W-1:0]       in_tdata,   // [10:0] position, [42:11] delta
  input  logic                                in_tuser,   // [0] operation
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fps_pkg::SUM_W-1:0]           out_tdata,  // [63:0] prefix_total
  // Register port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [fps_pkg::APB_ADDR_W-1:0]      cfg_paddr,
  input  logic [fps_pkg::APB_DATA_W-1:0]      cfg_pwdata,
  output logic [fps_pkg::APB_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  fps_pkg::state_t state_r, state_nxt;

  logic [fps_pkg::SIZE_W-1:0]  size_r;
  logic [fps_pkg::IDX_W-1:0]   idx_r;
  logic [fps_pkg::ADDR_W-1:0]  wb_addr_r;
  logic [fps_pkg::ADDR_W-1:0]  clr_cnt_r;
  logic                        pend_r;
  logic [fps_pkg::DELTA_W-1:0] delta_r;
  logic [fps_pkg::SUM_W-1:0]   acc_r;
  logic                        out_tvalid_r;
  logic [fps_pkg::SUM_W-1:0]   out_data_r;

  logic [fps_pkg::SUM_W-1:0]   mem [fps_pkg::DEPTH];
  logic [fps_pkg::SUM_W-1:0]   rd_data_r;

  logic                        in_fire;
  logic                        op_query;
  logic [fps_pkg::IDX_W-1:0]   pos_ext;
  logic [fps_pkg::IDX_W-1:0]   pos_sat;
  logic [fps_pkg::IDX_W-1:0]   bound;
  logic                        upd_ok;
  logic [fps_pkg::IDX_W-1:0]   idx_m1;
  logic [fps_pkg::IDX_W-1:0]   low_bit;
  logic [fps_pkg::SUM_W-1:0]   delta_ext;

  logic                        rd_en;
  logic [fps_pkg::ADDR_W-1:0]  rd_addr;
  logic                        wr_en;
  logic [fps_pkg::ADDR_W-1:0]  wr_addr;
  logic [fps_pkg::SUM_W-1:0]   wr_data;
  logic                        load_out;
  logic                        cfg_wr;
  logic                        clr_last;

  // Decode the input transaction
  assign in_tready = (state_r == fps_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign op_query  = (in_tuser == fps_pkg::OP_QUERY);
  assign pos_ext   = fps_pkg::IDX_W'(in_tdata[fps_pkg::POS_W-1:0]);
  assign pos_sat   = (pos_ext > fps_pkg::IDX_W'(fps_pkg::DEPTH))
                     ? fps_pkg::IDX_W'(fps_pkg::DEPTH) : pos_ext;

  // Update bound is the smaller of the register and the depth
  assign bound  = (fps_pkg::IDX_W'(size_r) > fps_pkg::IDX_W'(fps_pkg::DEPTH))
                  ? fps_pkg::IDX_W'(fps_pkg::DEPTH) : fps_pkg::IDX_W'(size_r);
  assign upd_ok = (pos_ext != '0) && (pos_ext <= bound);

  // Walk arithmetic
  assign idx_m1    = idx_r - fps_pkg::IDX_W'(1);
  assign low_bit   = idx_r & (~idx_r + fps_pkg::IDX_W'(1));
  assign rd_addr   = idx_m1[fps_pkg::ADDR_W-1:0];
  assign delta_ext = {{(fps_pkg::SUM_W-fps_pkg::DELTA_W){delta_r[fps_pkg::DELTA_W-1]}}, delta_r};
  assign clr_last  = (clr_cnt_r == fps_pkg::ADDR_W'(fps_pkg::DEPTH - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fps_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = fps_pkg::ST_IDLE;
      end
      fps_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (op_query)    state_nxt = fps_pkg::ST_QRY;
          else if (upd_ok) state_nxt = fps_pkg::ST_UPD;
        end
      end
      fps_pkg::ST_UPD: begin
        if (idx_r > bound) state_nxt = fps_pkg::ST_IDLE;
      end
      fps_pkg::ST_QRY: begin
        if (load_out) state_nxt = fps_pkg::ST_IDLE;
      end
      default: state_nxt = fps_pkg::ST_IDLE;
    endcase
  end

  // Memory port control and result load
  always_comb begin
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wb_addr_r;
    wr_data  = rd_data_r + delta_ext;
    load_out = 1'b0;
    case (state_r)
      fps_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '0;
      end
      fps_pkg::ST_IDLE: begin
      end
      fps_pkg::ST_UPD: begin
        wr_en = pend_r;
        rd_en = (idx_r <= bound);
      end
      fps_pkg::ST_QRY: begin
        rd_en    = (idx_r != '0);
        load_out = !pend_r && (idx_r == '0) && (!out_tvalid_r || out_tready);
      end
      default: begin
      end
    endcase
  end

  // Partial-sum memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fps_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= rd_en;
      if (state_r == fps_pkg::ST_CLEAR) clr_cnt_r <= clr_cnt_r + fps_pkg::ADDR_W'(1);
      if (load_out)        out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // Walk index, write-back address, accumulator and result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r   <= op_query ? pos_sat : pos_ext;
      delta_r <= in_tdata[fps_pkg::POS_W +: fps_pkg::DELTA_W];
      acc_r   <= '0;
    end else begin
      if (rd_en) begin
        wb_addr_r <= rd_addr;
        if (state_r == fps_pkg::ST_UPD) idx_r <= idx_r + low_bit;
        else                            idx_r <= idx_r & idx_m1;
      end
      if (state_r == fps_pkg::ST_QRY && pend_r) acc_r <= acc_r + rd_data_r;
    end
    if (load_out) out_data_r <= acc_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

  // Register port: write on the access phase, read back zero-extended
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr[fps_pkg::APB_ADDR_W-1:2] == fps_pkg::REG_SIZE_IN_USE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= fps_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      size_r <= cfg_pwdata[fps_pkg::SIZE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[fps_pkg::APB_ADDR_W-1:2] == fps_pkg::REG_SIZE_IN_USE)
                      ? fps_pkg::APB_DATA_W'(size_r) : '0;

  // No memory write while waiting for an item
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fps_pkg::ST_IDLE) |-> !wr_en)
    else $error("memory written while idle");

  // Reads stay on one-based nodes inside the store
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (idx_r != '0) && (idx_r <= fps_pkg::IDX_W'(fps_pkg::DEPTH)))
    else $error("walk read outside the store");

  // A result appears only at the end of a query walk
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> ($past(state_r) == fps_pkg::ST_QRY))
    else $error("result raised outside a query");

  // Write-back of an update follows its read in the cycle after it
  a_writeback_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fps_pkg::ST_UPD && wr_en) |-> $past(rd_en))
    else $error("update write-back without a preceding read");

endmodule
